// ===== rtl/rcl_pkg.sv =====
// Shared constants and opcodes for the rotor cipher letter stream block.
// No dependencies.
package rcl_pkg;

    localparam int ALPHA_SIZE = 26;
    localparam int ALPHA_LAST = 25;

    localparam logic [1:0] OP_CIPHER = 2'd0;
    localparam logic [1:0] OP_TABLE  = 2'd1;
    localparam logic [1:0] OP_OFFSET = 2'd2;

    localparam logic [7:0] ASCII_LC_A = 8'd97;
    localparam logic [7:0] ASCII_LC_Z = 8'd122;
    localparam logic [7:0] ASCII_UC_A = 8'd65;
    localparam logic [7:0] ASCII_UC_Z = 8'd90;

endpackage

// ===== rtl/rotor_cipher_letter_stream_core.sv =====
// Rotor cipher letter stream, top level. With n wheels in use (capped at MAX_WHEELS) a
// letter makes 2n+1 dependent table reads, each an address state then a registered data
// state. Input stalls until the odometer step ends, and also while the emit state waits
// on an output stall; the odometer step visits 1..n wheels (none if n = 0). Load
// transfers and ignored bytes do not stall the input. Synchronous
// active-low reset: offsets zero, used wheels 3, no result pending; rule tables unset.
module rotor_cipher_letter_stream_core
    import rcl_pkg::*;
#(
    parameter int MAX_WHEELS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_char_in,
    input  logic [3:0] i_wheel_select,
    input  logic       i_table_dir,
    input  logic [4:0] i_table_pos,
    input  logic [4:0] i_load_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_char_out
);

    localparam int TBL_DEPTH = (MAX_WHEELS + 1) * ALPHA_SIZE;
    localparam int MAW       = $clog2(2 * TBL_DEPTH);

    logic [3:0]     r_used_wheels;
    logic           ram_we;
    logic [MAW-1:0] ram_waddr;
    logic [4:0]     ram_wdata;
    logic [MAW-1:0] ram_raddr;
    logic [4:0]     ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_wheels <= 4'd3;
        end else if (i_cfg_valid) begin
            r_used_wheels <= i_cfg_data;
        end
    end

    rcl_rule_ram #(
        .DEPTH (2 * TBL_DEPTH),
        .AW    (MAW),
        .DW    (5)
    ) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rcl_ctrl #(
        .MAX_WHEELS (MAX_WHEELS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_used_wheels  (r_used_wheels),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_char_in      (i_char_in),
        .i_wheel_select (i_wheel_select),
        .i_table_dir    (i_table_dir),
        .i_table_pos    (i_table_pos),
        .i_load_value   (i_load_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_char_out     (o_char_out),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

endmodule

// ===== rtl/rcl_rule_ram.sv =====
// Wiring rule memory: one write port, one read port, registered read data.
// No package dependency; instantiated by the top level.
module rcl_rule_ram #(
    parameter int DEPTH = 468,
    parameter int AW    = 9,
    parameter int DW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rcl_ctrl.sv =====
// Sequencer for the rotor cipher: rotor offsets, wheel pass, odometer step,
// output register. Depends on rcl_pkg; drives the rule memory ports.
module rcl_ctrl
    import rcl_pkg::*;
#(
    parameter int MAX_WHEELS = 8,
    parameter int WCW        = $clog2(MAX_WHEELS + 1),
    parameter int TBL_DEPTH  = (MAX_WHEELS + 1) * ALPHA_SIZE,
    parameter int MAW        = $clog2(2 * TBL_DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [3:0]     i_used_wheels,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_opcode,
    input  logic [7:0]     i_char_in,
    input  logic [3:0]     i_wheel_select,
    input  logic           i_table_dir,
    input  logic [4:0]     i_table_pos,
    input  logic [4:0]     i_load_value,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [6:0]     o_char_out,
    output logic           o_ram_we,
    output logic [MAW-1:0] o_ram_waddr,
    output logic [4:0]     o_ram_wdata,
    output logic [MAW-1:0] o_ram_raddr,
    input  logic [4:0]     i_ram_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WB   = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_STEP = 3'd4;

    localparam logic [1:0] PH_FWD  = 2'd0;
    localparam logic [1:0] PH_REFL = 2'd1;
    localparam logic [1:0] PH_REV  = 2'd2;

    localparam logic [WCW-1:0] WHEEL_ONE = WCW'(1);

    logic [2:0]     r_state, n_state;
    logic [1:0]     r_phase, n_phase;
    logic [WCW-1:0] r_wheel, n_wheel;
    logic [WCW-1:0] r_count, n_count;
    logic [4:0]     r_idx, n_idx;
    logic [4:0]     r_p, n_p;
    logic           r_out_valid, n_out_valid;
    logic [6:0]     r_char, n_char;
    logic [4:0]     r_off [MAX_WHEELS+1];

    logic           accept;
    logic           sel_ok;
    logic [WCW-1:0] sel_w;
    logic           is_lower, is_upper;
    logic [WCW-1:0] cfg_count;
    logic [4:0]     cur_off;
    logic [5:0]     sum_p;
    logic [4:0]     p_mod;
    logic [5:0]     sum_r;
    logic [4:0]     r_mod;
    logic           off_we;
    logic [WCW-1:0] off_waddr;
    logic [4:0]     off_wdata;

    assign accept   = i_in_valid && !o_in_stall;
    assign sel_ok   = 32'(i_wheel_select) <= MAX_WHEELS;
    assign sel_w    = WCW'(i_wheel_select);
    assign is_lower = i_char_in >= ASCII_LC_A && i_char_in <= ASCII_LC_Z;
    assign is_upper = i_char_in >= ASCII_UC_A && i_char_in <= ASCII_UC_Z;
    assign cfg_count = (32'(i_used_wheels) > MAX_WHEELS) ? WCW'(MAX_WHEELS)
                                                         : WCW'(i_used_wheels);

    assign cur_off = r_off[r_wheel];
    assign sum_p   = 6'(r_idx) + 6'(cur_off);
    assign p_mod   = (sum_p >= 6'(ALPHA_SIZE)) ? 5'(sum_p - 6'(ALPHA_SIZE)) : 5'(sum_p);

    // rule values may exceed 25, so the sum can need two corrections
    assign sum_r = 6'(r_p) + 6'(i_ram_rdata);
    always_comb begin
        if (sum_r >= 6'(2 * ALPHA_SIZE)) begin
            r_mod = 5'(sum_r - 6'(2 * ALPHA_SIZE));
        end else if (sum_r >= 6'(ALPHA_SIZE)) begin
            r_mod = 5'(sum_r - 6'(ALPHA_SIZE));
        end else begin
            r_mod = 5'(sum_r);
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // table writes go straight to memory at the transfer edge
    assign o_ram_we    = accept && i_opcode == OP_TABLE && sel_ok &&
                         32'(i_table_pos) < ALPHA_SIZE;
    assign o_ram_waddr = (i_table_dir ? MAW'(TBL_DEPTH) : MAW'(0)) +
                         MAW'(sel_w) * MAW'(ALPHA_SIZE) + MAW'(i_table_pos);
    assign o_ram_wdata = i_load_value;
    assign o_ram_raddr = ((r_phase == PH_REV) ? MAW'(TBL_DEPTH) : MAW'(0)) +
                         MAW'(r_wheel) * MAW'(ALPHA_SIZE) + MAW'(p_mod);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_wheel     = r_wheel;
        n_count     = r_count;
        n_idx       = r_idx;
        n_p         = r_p;
        n_char      = r_char;
        n_out_valid = r_out_valid && i_out_stall;
        off_we      = 1'b0;
        off_waddr   = sel_w;
        off_wdata   = i_load_value;

        unique case (r_state)
            S_IDLE: begin
                if (accept && i_opcode == OP_OFFSET) begin
                    off_we = sel_ok && 32'(i_load_value) < ALPHA_SIZE;
                end
                if (accept && i_opcode == OP_CIPHER && (is_lower || is_upper)) begin
                    n_idx   = is_lower ? 5'(i_char_in - ASCII_LC_A)
                                       : 5'(i_char_in - ASCII_UC_A);
                    n_count = cfg_count;
                    n_state = S_RD;
                    if (cfg_count == '0) begin
                        n_phase = PH_REFL;
                        n_wheel = '0;
                    end else begin
                        n_phase = PH_FWD;
                        n_wheel = WHEEL_ONE;
                    end
                end
            end
            S_RD: begin
                n_p     = p_mod;
                n_state = S_WB;
            end
            S_WB: begin
                n_idx   = r_mod;
                n_state = S_RD;
                unique case (r_phase)
                    PH_FWD: begin
                        if (r_wheel == r_count) begin
                            n_phase = PH_REFL;
                            n_wheel = '0;
                        end else begin
                            n_wheel = r_wheel + WHEEL_ONE;
                        end
                    end
                    PH_REFL: begin
                        if (r_count == '0) begin
                            n_state = S_EMIT;
                        end else begin
                            n_phase = PH_REV;
                            n_wheel = r_count;
                        end
                    end
                    PH_REV: begin
                        if (r_wheel == WHEEL_ONE) begin
                            n_state = S_EMIT;
                        end else begin
                            n_wheel = r_wheel - WHEEL_ONE;
                        end
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_char      = 7'(ASCII_LC_A) + 7'(r_idx);
                    n_wheel     = WHEEL_ONE;
                    n_state     = (r_count == '0) ? S_IDLE : S_STEP;
                end
            end
            S_STEP: begin
                // odometer: carry moves up one wheel per cycle
                off_we    = 1'b1;
                off_waddr = r_wheel;
                if (32'(cur_off) < ALPHA_LAST) begin
                    off_wdata = cur_off + 5'd1;
                    n_state   = S_IDLE;
                end else begin
                    off_wdata = '0;
                    if (r_wheel == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        n_wheel = r_wheel + WHEEL_ONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i <= MAX_WHEELS; i++) begin
                r_off[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (off_we) begin
                r_off[off_waddr] <= off_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_wheel <= n_wheel;
        r_count <= n_count;
        r_idx   <= n_idx;
        r_p     <= n_p;
        r_char  <= n_char;
    end

    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_char;

endmodule
